>>> design/urta_pkg.sv
// Shared types, codes and defaults for the region table allocator.
package urta_pkg;

    // Parameter defaults
    localparam int unsigned SLOTS_DEF     = 16;
    localparam int unsigned ALIGN_DEF     = 8;
    localparam int unsigned ENTRY_HDR_DEF = 24;
    localparam int unsigned ARENA_HDR_DEF = 272;

    // Command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_RESET  = 2'd3
    } cmd_t;

    // Status codes carried on m_tuser
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_UNAVAIL   = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_NO_SPACE  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE,
        S_ALIGN_Q,
        S_ALIGN_B
    } state_t;

    // Register word select (paddr[2])
    localparam logic REG_ARENA_BASE = 1'b0;
    localparam logic REG_ARENA_LEN  = 1'b1;

    // One table slot
    typedef struct packed {
        logic [31:0] uid;
        logic [31:0] offset;
        logic [31:0] size;
        logic [7:0]  rtype;
    } entry_t;

    // Per-cell tap: zero unless this cell is the first hit or the last valid slot
    typedef struct packed {
        logic [31:0] f_off;
        logic [31:0] f_size;
        logic [7:0]  f_type;
        logic [31:0] f_next_off;
        logic [31:0] gap;
        logic        f_last;
        logic [31:0] last_end;
    } tap_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic        capture;
        logic        shift_en;
        logic        append_en;
        logic [31:0] gap;
        entry_t      new_entry;
    } ctl_t;

endpackage

>>> design/urta_cell.sv
// One slot of the region table: uid match, first-hit chain, compaction shift and append load.
module urta_cell #(
    parameter int unsigned ENTRY_HDR_BYTES = urta_pkg::ENTRY_HDR_DEF
) (
    input  logic             clk,
    input  logic [31:0]      key,
    input  logic             valid,
    input  logic             prev_valid,
    input  logic             next_valid,
    input  logic             hit_in,
    input  urta_pkg::entry_t nb,
    input  urta_pkg::ctl_t   ctl,
    output urta_pkg::entry_t entry,
    output logic             hit_out,
    output urta_pkg::tap_t   tap
);

    urta_pkg::entry_t entry_reg;
    urta_pkg::entry_t shifted_w;
    logic             after_reg;
    logic             hit_here;
    logic             first;
    logic             is_last;
    logic [31:0]      end_w;

    // Match and first-hit chain
    assign hit_here = valid & (entry_reg.uid == key);
    assign first    = hit_here & ~hit_in;
    assign hit_out  = hit_in | hit_here;
    assign is_last  = valid & ~next_valid;
    assign end_w    = entry_reg.offset + 32'(ENTRY_HDR_BYTES) + entry_reg.size;
    assign entry    = entry_reg;

    // Taps for the sequencer
    always_comb
    begin
        tap = '0;
        if (first)
        begin
            tap.f_off      = entry_reg.offset;
            tap.f_size     = entry_reg.size;
            tap.f_type     = entry_reg.rtype;
            tap.f_next_off = nb.offset;
            tap.gap        = nb.offset - entry_reg.offset;
            tap.f_last     = is_last;
        end
        if (is_last)
        begin
            tap.last_end = end_w;
        end
    end

    // Neighbor entry moved down by the freed gap
    always_comb
    begin
        shifted_w        = nb;
        shifted_w.offset = nb.offset - ctl.gap;
    end

    // Slot storage: take the neighbor on compaction, the new entry on append
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            after_reg <= hit_out;
        end
        if (ctl.shift_en && after_reg && next_valid)
        begin
            entry_reg <= shifted_w;
        end
        else if (ctl.append_en && !valid && prev_valid)
        begin
            entry_reg <= ctl.new_entry;
        end
    end

endmodule

>>> design/uid_region_table_allocator.sv
// Top level of the region table allocator: sequencer, cell row, align unit, APB registers.
//
// Commands arrive as beats on the s_ channel (tuser = command, tdata = uid, size,
// type); each beat yields exactly one result beat on the m_ channel (tuser =
// status, tdata = address, size, type, move span and clear span). The table is
// a row of SLOTS cells that all compare the uid at once; a remove shifts every
// later cell down from its neighbor.
// An accepted command beat passes through the compare and update states; its result
// beat is loaded into the result register when the update commits. A successful
// create or a remove of a non-tail region then also passes the align states: the new
// bump pointer goes through the align unit (reciprocal multiply in S_ALIGN_Q, then
// multiply back in S_ALIGN_B), and the next command waits for it.
// The output register holds the last result, so a new command is taken while
// it waits; if the receiver still stalls at the update cycle, the block holds
// there until the result register frees.
// Reset empties the table, sets the bump pointer to the arena header size and
// clears arena_base and arena_len, which leaves the block disabled (every
// command answers "not available") until both are written nonzero over APB.
module uid_region_table_allocator #(
    parameter int unsigned SLOTS           = urta_pkg::SLOTS_DEF,
    parameter int unsigned ALIGN_BYTES     = urta_pkg::ALIGN_DEF,
    parameter int unsigned ENTRY_HDR_BYTES = urta_pkg::ENTRY_HDR_DEF,
    parameter int unsigned ARENA_HDR_BYTES = urta_pkg::ARENA_HDR_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // command channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // uid[31:0], req_size[63:32], region_type[71:64]
    input  logic [1:0]   s_tuser,  // cmd[1:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // region_addr[31:0], size_found[63:32], type_found[71:64], move_src[103:72],
    // move_dst[135:104], move_len[167:136], clear_start[199:168], clear_len[231:200]
    output logic [231:0] m_tdata,
    output logic [1:0]   m_tuser,  // status[1:0]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned CW      = $clog2(SLOTS + 1);
    localparam int unsigned ALIGN_L = $clog2(ALIGN_BYTES);
    localparam int unsigned SHIFT   = 32 + ALIGN_L;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [32:0] RECIP = RECIP_FULL[32:0];
    localparam int unsigned AW  = $clog2(ALIGN_BYTES + 1);
    localparam int unsigned BPW = 33 + AW;
    localparam logic [AW-1:0] ALIGN_V = AW'(ALIGN_BYTES);

    // Configuration registers
    logic [31:0] arena_base_reg;
    logic [31:0] arena_len_reg;

    // Sequencer and table state
    urta_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic [31:0]      bump_reg;

    // Accepted command
    urta_pkg::cmd_t cmd_reg;
    logic [31:0]    uid_reg;
    logic [31:0]    req_reg;
    logic [7:0]     type_reg;

    // Compare-cycle captures
    logic           hit_reg;
    urta_pkg::tap_t tap_reg;
    logic [33:0]    end_reg;
    logic [33:0]    base_end_reg;

    // Align unit
    logic [31:0]    x_reg;
    logic [31:0]    q_reg;
    logic [64:0]    prod_w;
    logic [BPW-1:0] bprod_w;
    logic [31:0]    aligned_w;

    // Result register
    logic           m_tvalid_reg;
    logic [1:0]     status_reg;
    logic [231:0]   data_reg;

    // Update-cycle decisions
    logic           enabled;
    logic           out_free;
    logic           commit;
    logic           create_ok;
    logic           remove_hit;
    logic           need_align;
    logic [1:0]     res_status;
    logic [31:0]    res_addr, res_size, res_src, res_dst, res_mlen, res_cs, res_cl;
    logic [7:0]     res_type;
    logic [31:0]    x_next;

    // Cell row wiring
    urta_pkg::entry_t entry_arr [SLOTS];
    urta_pkg::tap_t   tap_arr   [SLOTS];
    logic [SLOTS:0]   hit_chain;
    logic [SLOTS-1:0] valid_vec;
    urta_pkg::tap_t   tap_or;
    urta_pkg::ctl_t   ctl;

    // APB port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == urta_pkg::REG_ARENA_LEN) ? arena_len_reg : arena_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg <= '0;
            arena_len_reg  <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == urta_pkg::REG_ARENA_LEN)
            begin
                arena_len_reg <= pwdata;
            end
            else
            begin
                arena_base_reg <= pwdata;
            end
        end
    end

    // Cell row
    assign hit_chain[0] = 1'b0;

    for (genvar j = 0; j < SLOTS; j++)
    begin : g_cell
        urta_pkg::entry_t nb_w;
        logic             next_v;
        logic             prev_v;

        assign valid_vec[j] = (count_reg > CW'(j));

        if (j == SLOTS - 1)
        begin : g_tail
            assign nb_w   = '0;
            assign next_v = 1'b0;
        end
        else
        begin : g_mid
            assign nb_w   = entry_arr[j+1];
            assign next_v = (count_reg > CW'(j + 1));
        end

        if (j == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = valid_vec[j-1];
        end

        urta_cell #(
            .ENTRY_HDR_BYTES(ENTRY_HDR_BYTES)
        ) u_cell (
            .clk        (clk),
            .key        (uid_reg),
            .valid      (valid_vec[j]),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .hit_in     (hit_chain[j]),
            .nb         (nb_w),
            .ctl        (ctl),
            .entry      (entry_arr[j]),
            .hit_out    (hit_chain[j+1]),
            .tap        (tap_arr[j])
        );
    end

    // Collect taps: at most one cell drives each field
    always_comb
    begin
        tap_or = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            tap_or = urta_pkg::tap_t'(tap_or | tap_arr[j]);
        end
    end

    // Update-cycle result and actions
    assign enabled  = (|arena_base_reg) & (|arena_len_reg);
    assign out_free = ~m_tvalid_reg | m_tready;
    assign commit   = (state_reg == urta_pkg::S_UPDATE) & out_free;

    always_comb
    begin
        res_status = urta_pkg::STS_OK;
        res_addr   = '0;
        res_size   = '0;
        res_type   = '0;
        res_src    = '0;
        res_dst    = '0;
        res_mlen   = '0;
        res_cs     = '0;
        res_cl     = '0;
        create_ok  = 1'b0;
        remove_hit = 1'b0;
        need_align = 1'b0;
        x_next     = tap_reg.last_end - tap_reg.gap;
        if (!enabled)
        begin
            res_status = urta_pkg::STS_UNAVAIL;
        end
        else
        begin
            case (cmd_reg)
                urta_pkg::CMD_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        res_addr = arena_base_reg + tap_reg.f_off + 32'(ENTRY_HDR_BYTES);
                        res_size = tap_reg.f_size;
                        res_type = tap_reg.f_type;
                    end
                    else
                    begin
                        res_status = urta_pkg::STS_NOT_FOUND;
                    end
                end
                urta_pkg::CMD_CREATE:
                begin
                    if ((count_reg >= CW'(SLOTS)) || hit_reg || (bump_reg >= arena_len_reg) ||
                        (end_reg > {2'b00, arena_len_reg}) || (|base_end_reg[33:32]))
                    begin
                        res_status = urta_pkg::STS_NO_SPACE;
                    end
                    else
                    begin
                        create_ok  = 1'b1;
                        need_align = 1'b1;
                        x_next     = end_reg[31:0];
                        res_addr   = arena_base_reg + bump_reg + 32'(ENTRY_HDR_BYTES);
                    end
                end
                urta_pkg::CMD_REMOVE:
                begin
                    if (!hit_reg)
                    begin
                        res_status = urta_pkg::STS_NOT_FOUND;
                    end
                    else if (tap_reg.f_last)
                    begin
                        remove_hit = 1'b1;
                        res_cs     = tap_reg.f_off;
                        res_cl     = 32'(ENTRY_HDR_BYTES) + tap_reg.f_size;
                    end
                    else
                    begin
                        remove_hit = 1'b1;
                        need_align = 1'b1;
                        res_src    = tap_reg.f_next_off;
                        res_dst    = tap_reg.f_off;
                        res_mlen   = tap_reg.last_end - tap_reg.f_next_off;
                        res_cs     = tap_reg.last_end - tap_reg.gap;
                        res_cl     = tap_reg.gap;
                    end
                end
                default:
                begin
                    res_cl = arena_len_reg;
                end
            endcase
        end
    end

    // Broadcast to the cells
    always_comb
    begin
        ctl                 = '0;
        ctl.capture         = (state_reg == urta_pkg::S_COMPARE);
        ctl.shift_en        = commit & remove_hit;
        ctl.append_en       = commit & create_ok;
        ctl.gap             = tap_reg.gap;
        ctl.new_entry.uid    = uid_reg;
        ctl.new_entry.offset = bump_reg;
        ctl.new_entry.size   = req_reg;
        ctl.new_entry.rtype  = type_reg;
    end

    // Align unit: floor(x / A) by reciprocal, then (q + 1) * A saturated
    assign prod_w    = 65'(x_reg) * 65'(RECIP);
    assign bprod_w   = (BPW'(q_reg) + BPW'(1)) * BPW'(ALIGN_V);
    assign aligned_w = (|bprod_w[BPW-1:32]) ? '1 : bprod_w[31:0];

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urta_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            urta_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = urta_pkg::S_COMPARE;
                end
            end
            urta_pkg::S_COMPARE:
            begin
                state_next = urta_pkg::S_UPDATE;
            end
            urta_pkg::S_UPDATE:
            begin
                if (out_free)
                begin
                    if (need_align)
                    begin
                        state_next = urta_pkg::S_ALIGN_Q;
                    end
                    else
                    begin
                        s_tready   = 1'b1;
                        state_next = s_tvalid ? urta_pkg::S_COMPARE : urta_pkg::S_IDLE;
                    end
                end
            end
            urta_pkg::S_ALIGN_Q:
            begin
                state_next = urta_pkg::S_ALIGN_B;
            end
            urta_pkg::S_ALIGN_B:
            begin
                s_tready   = 1'b1;
                state_next = s_tvalid ? urta_pkg::S_COMPARE : urta_pkg::S_IDLE;
            end
            default:
            begin
                state_next = urta_pkg::S_IDLE;
            end
        endcase
    end

    // Command capture and compare-cycle registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= urta_pkg::cmd_t'(s_tuser);
            uid_reg  <= s_tdata[31:0];
            req_reg  <= s_tdata[63:32];
            type_reg <= s_tdata[71:64];
        end
        if (state_reg == urta_pkg::S_COMPARE)
        begin
            hit_reg      <= hit_chain[SLOTS];
            tap_reg      <= tap_or;
            end_reg      <= 34'(bump_reg) + 34'(ENTRY_HDR_BYTES) + 34'(req_reg);
            base_end_reg <= 34'(arena_base_reg) + 34'(bump_reg) + 34'(ENTRY_HDR_BYTES) +
                            34'(req_reg);
        end
        if (commit && need_align)
        begin
            x_reg <= x_next;
        end
        if (state_reg == urta_pkg::S_ALIGN_Q)
        begin
            q_reg <= 32'(prod_w >> SHIFT);
        end
        if (commit)
        begin
            status_reg <= res_status;
            data_reg   <= {res_cl, res_cs, res_mlen, res_dst, res_src, res_type, res_size,
                           res_addr};
        end
    end

    // Table count, bump pointer and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            bump_reg     <= 32'(ARENA_HDR_BYTES);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (commit && enabled)
            begin
                if (create_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (remove_hit)
                begin
                    count_reg <= count_reg - CW'(1);
                    if (tap_reg.f_last)
                    begin
                        bump_reg <= tap_reg.f_off;
                    end
                end
                else if (cmd_reg == urta_pkg::CMD_RESET)
                begin
                    count_reg <= '0;
                    bump_reg  <= 32'(ARENA_HDR_BYTES);
                end
            end

            if (state_reg == urta_pkg::S_ALIGN_B)
            begin
                bump_reg <= aligned_w;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = data_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("table count above slot count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (commit) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && enabled && remove_hit) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not shrink the table");

    a_align_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == urta_pkg::S_ALIGN_B) |=> (bump_reg >= $past(x_reg)))
        else $error("aligned bump pointer below region end");

endmodule
